@@ design/sdds_pkg.sv @@
// Shared types and constants for the scan, detect and dwell sequencer.
// Used by the register block, the sequencer core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sdds_pkg;

	localparam int TIMER_WIDTH = 16;
	localparam int CYCLE_WIDTH = 8;
	localparam int LIM_W       = 16;
	localparam int SEEN_W      = 17;
	localparam int TCMP_W      = (TIMER_WIDTH > LIM_W) ? TIMER_WIDTH : LIM_W;
	localparam int CCMP_W      = (CYCLE_WIDTH > 8) ? CYCLE_WIDTH : 8;
	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;

	localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};
	localparam logic [CYCLE_WIDTH-1:0] CYCLE_MAX = {CYCLE_WIDTH{1'b1}};
	localparam logic [SEEN_W-1:0]      SEEN_MAX  = {SEEN_W{1'b1}};

	localparam logic [7:0]       RST_MOTOR_SPEED = 8'd128;
	localparam logic [LIM_W-1:0] RST_RUN_TIME    = 16'd2000;
	localparam logic [LIM_W-1:0] RST_PAUSE       = 16'd1500;
	localparam logic [LIM_W-1:0] RST_IR_HOLD     = 16'd250;
	localparam logic [LIM_W-1:0] RST_DWELL       = 16'd2000;
	localparam logic [7:0]       RST_CYCLE_LIMIT = 8'd5;
	localparam logic [LIM_W-1:0] RST_START_DELAY = 16'd2000;

	typedef enum logic [2:0] {
		REG_MOTOR_SPEED = 3'd0,
		REG_RUN_TIME    = 3'd1,
		REG_PAUSE       = 3'd2,
		REG_IR_HOLD     = 3'd3,
		REG_DWELL       = 3'd4,
		REG_CYCLE_LIMIT = 3'd5,
		REG_START_DELAY = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		PH_WAIT  = 3'd0,
		PH_RUN   = 3'd1,
		PH_DWELL = 3'd2,
		PH_PAUSE = 3'd3,
		PH_DONE  = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_FOUND = 3'd1,
		EV_SCORE = 3'd2,
		EV_LOST  = 3'd3,
		EV_DONE  = 3'd4
	} event_t;

	typedef struct packed {
		logic [7:0]       motor_speed;
		logic [LIM_W-1:0] run_time_ms;
		logic [LIM_W-1:0] pause_ms;
		logic [LIM_W-1:0] ir_hold_ms;
		logic [LIM_W-1:0] dwell_ms;
		logic [7:0]       cycle_limit;
		logic [LIM_W-1:0] start_delay_ms;
	} cfg_t;

	typedef struct packed {
		logic [7:0] motor_duty;
		logic       turn_direction;
		logic       laser_on;
		logic [2:0] event_code;
		logic [7:0] cycle_index;
	} result_t;

endpackage

`default_nettype wire

@@ design/sdds_regs.sv @@
// APB configuration registers of the sequencer.
// Depends on sdds_pkg for the register map and the cfg_t struct.
`timescale 1ns / 1ps
`default_nettype none

module sdds_regs import sdds_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	logic     wr_en;
	reg_idx_t idx;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;
	assign idx    = reg_idx_t'(paddr[4:2]);
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motor_speed    <= RST_MOTOR_SPEED;
			cfg_q.run_time_ms    <= RST_RUN_TIME;
			cfg_q.pause_ms       <= RST_PAUSE;
			cfg_q.ir_hold_ms     <= RST_IR_HOLD;
			cfg_q.dwell_ms       <= RST_DWELL;
			cfg_q.cycle_limit    <= RST_CYCLE_LIMIT;
			cfg_q.start_delay_ms <= RST_START_DELAY;
		end else if (wr_en) begin
			unique case (idx)
				REG_MOTOR_SPEED: cfg_q.motor_speed    <= pwdata[7:0];
				REG_RUN_TIME:    cfg_q.run_time_ms    <= pwdata[LIM_W-1:0];
				REG_PAUSE:       cfg_q.pause_ms       <= pwdata[LIM_W-1:0];
				REG_IR_HOLD:     cfg_q.ir_hold_ms     <= pwdata[LIM_W-1:0];
				REG_DWELL:       cfg_q.dwell_ms       <= pwdata[LIM_W-1:0];
				REG_CYCLE_LIMIT: cfg_q.cycle_limit    <= pwdata[7:0];
				REG_START_DELAY: cfg_q.start_delay_ms <= pwdata[LIM_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_MOTOR_SPEED: prdata = DATA_W'(cfg_q.motor_speed);
			REG_RUN_TIME:    prdata = DATA_W'(cfg_q.run_time_ms);
			REG_PAUSE:       prdata = DATA_W'(cfg_q.pause_ms);
			REG_IR_HOLD:     prdata = DATA_W'(cfg_q.ir_hold_ms);
			REG_DWELL:       prdata = DATA_W'(cfg_q.dwell_ms);
			REG_CYCLE_LIMIT: prdata = DATA_W'(cfg_q.cycle_limit);
			REG_START_DELAY: prdata = DATA_W'(cfg_q.start_delay_ms);
			default:         prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

@@ design/sdds_core.sv @@
// Sequencer state and its one-tick update: phase, timer, beacon age,
// cycle counter and direction. Depends on sdds_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdds_core import sdds_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic beacon_level,
	input  cfg_t      cfg,
	output result_t   result
);

	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic [SEEN_W-1:0]      seen_q, seen_d;
	logic [CYCLE_WIDTH-1:0] cnt_q, cnt_d;
	logic                   dir_q, dir_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			timer_q <= '0;
			seen_q  <= SEEN_MAX;
			cnt_q   <= CYCLE_WIDTH'(1);
			dir_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			timer_q <= timer_d;
			seen_q  <= seen_d;
			cnt_q   <= cnt_d;
			dir_q   <= dir_d;
		end
	end

	always_comb begin
		logic [TIMER_WIDTH-1:0] t_inc;
		logic [SEEN_W-1:0]      s_inc;
		logic [SEEN_W-1:0]      s_smp;
		logic                   detected;
		logic [CYCLE_WIDTH-1:0] cnt_inc;
		logic                   over_cur;
		logic                   over_inc;
		event_t                 ev;

		t_inc    = (timer_q == TIMER_MAX) ? timer_q : timer_q + 1'b1;
		s_inc    = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
		// A low level on a sampling tick restarts the beacon age.
		s_smp    = beacon_level ? s_inc : '0;
		detected = (s_smp <= SEEN_W'(cfg.ir_hold_ms));
		cnt_inc  = cnt_q + 1'b1;
		over_cur = CCMP_W'(cnt_q) > CCMP_W'(cfg.cycle_limit);
		over_inc = CCMP_W'(cnt_inc) > CCMP_W'(cfg.cycle_limit);

		phase_d = phase_q;
		timer_d = timer_q;
		seen_d  = s_inc;
		cnt_d   = cnt_q;
		dir_d   = dir_q;
		ev      = EV_NONE;

		unique case (phase_q)
			PH_WAIT: begin
				if (TCMP_W'(t_inc) >= TCMP_W'(cfg.start_delay_ms)) begin
					timer_d = '0;
					if (over_cur) begin
						phase_d = PH_DONE;
						ev      = EV_DONE;
					end else begin
						phase_d = PH_RUN;
						dir_d   = 1'b0;
					end
				end else begin
					timer_d = t_inc;
				end
			end
			PH_RUN: begin
				if (TCMP_W'(timer_q) >= TCMP_W'(cfg.run_time_ms)) begin
					phase_d = PH_PAUSE;
					timer_d = '0;
				end else begin
					seen_d = s_smp;
					if (detected) begin
						phase_d = PH_DWELL;
						timer_d = '0;
						ev      = EV_FOUND;
					end else begin
						timer_d = t_inc;
					end
				end
			end
			PH_DWELL: begin
				if (TCMP_W'(timer_q) >= TCMP_W'(cfg.dwell_ms)) begin
					phase_d = PH_PAUSE;
					timer_d = '0;
					ev      = EV_SCORE;
				end else begin
					seen_d = s_smp;
					if (!detected) begin
						phase_d = PH_PAUSE;
						timer_d = '0;
						ev      = EV_LOST;
					end else begin
						timer_d = t_inc;
					end
				end
			end
			PH_PAUSE: begin
				if (TCMP_W'(timer_q) >= TCMP_W'(cfg.pause_ms)) begin
					timer_d = '0;
					if (!dir_q) begin
						dir_d   = 1'b1;
						phase_d = PH_RUN;
					end else begin
						dir_d = 1'b0;
						// A counter at its top value ends the sequence.
						if (cnt_q == CYCLE_MAX) begin
							phase_d = PH_DONE;
							ev      = EV_DONE;
						end else begin
							cnt_d = cnt_inc;
							if (over_inc) begin
								phase_d = PH_DONE;
								ev      = EV_DONE;
							end else begin
								phase_d = PH_RUN;
							end
						end
					end
				end else begin
					timer_d = t_inc;
				end
			end
			default: begin
				phase_d = PH_DONE;
			end
		endcase

		result.motor_duty     = (phase_d == PH_RUN) ? cfg.motor_speed : 8'd0;
		result.turn_direction = dir_d;
		result.laser_on       = (phase_d == PH_DWELL);
		result.event_code     = ev;
		result.cycle_index    = 8'(cnt_d);
	end

endmodule

`default_nettype wire

@@ design/scan_detect_dwell_sequencer.sv @@
// Top level of the scan, detect and dwell sequencer: input register,
// result register and handshakes. Uses sdds_pkg, sdds_regs and sdds_core.
`timescale 1ns / 1ps
`default_nettype none

// One request is one millisecond tick carrying the raw active-low beacon
// level, and each request yields exactly one result. The block takes a new
// request every clock cycle unless out_stall holds a full result register.
// A result passes through the input register and then the result register
// before it is presented on the outputs; the whole tick update of the
// sequencer state is combinational logic between those two registers.
// Configuration writes over the APB port are meant for idle periods and
// affect the next tick.
module scan_detect_dwell_sequencer import sdds_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              beacon_level,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic      [7:0]        motor_duty,
	output logic                   turn_direction,
	output logic                   laser_on,
	output logic      [2:0]        event_code,
	output logic      [7:0]        cycle_index
);

	cfg_t    cfg;
	result_t res;
	result_t res_s2;
	logic    valid_s1;
	logic    beacon_s1;
	logic    valid_s2;
	logic    advance;

	sdds_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	// The input stage moves on whenever the result register is free or drains.
	assign advance  = valid_s1 & (~valid_s2 | ~out_stall);
	assign in_stall = valid_s1 & ~advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beacon_s1 <= beacon_level;
		end
	end

	sdds_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.beacon_level(beacon_s1),
		.cfg         (cfg),
		.result      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign motor_duty     = res_s2.motor_duty;
	assign turn_direction = res_s2.turn_direction;
	assign laser_on       = res_s2.laser_on;
	assign event_code     = res_s2.event_code;
	assign cycle_index    = res_s2.cycle_index;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for scan_detect_dwell_sequencer: random tick requests
// with random gaps and output stalls, checked against a cycle-free predictor.
// Depends on sdds_pkg and the sequencer RTL.
`timescale 1ns / 1ps
`default_nettype none

module testbench import sdds_pkg::*;;

	localparam int QUIET_LIMIT = 5000;

	// Predicts every tick result and holds those not yet returned by the block.
	class sequencer_scoreboard;
		cfg_t                   regs;
		phase_t                 phase;
		logic [TIMER_WIDTH-1:0] phase_timer;
		logic [SEEN_W-1:0]      since_seen;
		logic [CYCLE_WIDTH-1:0] cycle_count;
		logic                   turn;
		result_t                pending_results[$];
		int                     errors;

		function new();
			regs.motor_speed    = RST_MOTOR_SPEED;
			regs.run_time_ms    = RST_RUN_TIME;
			regs.pause_ms       = RST_PAUSE;
			regs.ir_hold_ms     = RST_IR_HOLD;
			regs.dwell_ms       = RST_DWELL;
			regs.cycle_limit    = RST_CYCLE_LIMIT;
			regs.start_delay_ms = RST_START_DELAY;
			phase       = PH_WAIT;
			phase_timer = '0;
			since_seen  = SEEN_MAX;
			cycle_count = CYCLE_WIDTH'(1);
			turn        = 1'b0;
			errors      = 0;
		endfunction

		function void write_setting(reg_idx_t idx, logic [15:0] value);
			case (idx)
				REG_MOTOR_SPEED: regs.motor_speed    = value[7:0];
				REG_RUN_TIME:    regs.run_time_ms    = value;
				REG_PAUSE:       regs.pause_ms       = value;
				REG_IR_HOLD:     regs.ir_hold_ms     = value;
				REG_DWELL:       regs.dwell_ms       = value;
				REG_CYCLE_LIMIT: regs.cycle_limit    = value[7:0];
				REG_START_DELAY: regs.start_delay_ms = value;
				default: ;
			endcase
		endfunction

		function void enter_phase(phase_t next);
			phase       = next;
			phase_timer = '0;
		endfunction

		function void bump_timer();
			if (phase_timer != TIMER_MAX)
				phase_timer++;
		endfunction

		// A low level restarts the hold window; detection holds while the age is at most ir_hold_ms.
		function bit beacon_held(bit level);
			if (!level)
				since_seen = '0;
			return since_seen <= regs.ir_hold_ms;
		endfunction

		function event_t start_cycle();
			if (cycle_count > regs.cycle_limit) begin
				enter_phase(PH_DONE);
				return EV_DONE;
			end
			turn = 1'b0;
			enter_phase(PH_RUN);
			return EV_NONE;
		endfunction

		function void note_tick(bit level);
			event_t  ev;
			result_t r;
			ev = EV_NONE;
			if (since_seen != SEEN_MAX)
				since_seen++;
			case (phase)
				PH_WAIT: begin
					bump_timer();
					if (phase_timer >= regs.start_delay_ms)
						ev = start_cycle();
				end
				PH_RUN: begin
					if (phase_timer >= regs.run_time_ms) begin
						enter_phase(PH_PAUSE);
					end else if (beacon_held(level)) begin
						enter_phase(PH_DWELL);
						ev = EV_FOUND;
					end else begin
						bump_timer();
					end
				end
				PH_DWELL: begin
					if (phase_timer >= regs.dwell_ms) begin
						enter_phase(PH_PAUSE);
						ev = EV_SCORE;
					end else if (!beacon_held(level)) begin
						enter_phase(PH_PAUSE);
						ev = EV_LOST;
					end else begin
						bump_timer();
					end
				end
				PH_PAUSE: begin
					if (phase_timer >= regs.pause_ms) begin
						if (!turn) begin
							turn = 1'b1;
							enter_phase(PH_RUN);
						end else begin
							turn = 1'b0;
							// A cycle counter at its top value ends the sequence outright.
							if (cycle_count == CYCLE_MAX) begin
								enter_phase(PH_DONE);
								ev = EV_DONE;
							end else begin
								cycle_count++;
								ev = start_cycle();
							end
						end
					end else begin
						bump_timer();
					end
				end
				default: phase = PH_DONE;
			endcase
			r.motor_duty     = (phase == PH_RUN) ? regs.motor_speed : 8'd0;
			r.turn_direction = turn;
			r.laser_on       = (phase == PH_DWELL);
			r.event_code     = ev;
			r.cycle_index    = cycle_count[7:0];
			pending_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (pending_results.size() == 0) begin
				$error("result %h arrived with no request pending", got);
				errors++;
				return;
			end
			want = pending_results.pop_front();
			compare_field("motor_duty", want.motor_duty, got.motor_duty);
			compare_field("turn_direction", 8'(want.turn_direction), 8'(got.turn_direction));
			compare_field("laser_on", 8'(want.laser_on), 8'(got.laser_on));
			compare_field("event_code", 8'(want.event_code), 8'(got.event_code));
			compare_field("cycle_index", want.cycle_index, got.cycle_index);
		endfunction
	endclass

	logic              clk;
	logic              arst_n       = 1'b0;
	logic              psel         = 1'b0;
	logic              penable      = 1'b0;
	logic              pwrite       = 1'b0;
	logic [ADDR_W-1:0] paddr        = '0;
	logic [DATA_W-1:0] pwdata       = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid     = 1'b0;
	logic              in_stall;
	logic              beacon_level = 1'b1;
	logic              out_valid;
	logic              out_stall    = 1'b0;
	logic [7:0]        motor_duty;
	logic              turn_direction;
	logic              laser_on;
	logic [2:0]        event_code;
	logic [7:0]        cycle_index;

	sequencer_scoreboard sb;
	bit                  calm = 1'b0;
	int                  stall_left = 0;
	int                  quiet_cycles = 0;

	scan_detect_dwell_sequencer i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.beacon_level   (beacon_level),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.motor_duty     (motor_duty),
		.turn_direction (turn_direction),
		.laser_on       (laser_on),
		.event_code     (event_code),
		.cycle_index    (cycle_index)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Mostly no gap, some short ones, a few long; none at all in calm stretches.
	function automatic int idle_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [15:0] pick_span(int top);
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return 16'($urandom_range(0, top));
		if (r < 93)
			return 16'($urandom_range(top + 1, 300));
		return 16'hFFFF;
	endfunction

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			stall_left = idle_len();
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result({motor_duty, turn_direction, laser_on, event_code, cycle_index});
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles = 0;
			else
				quiet_cycles = quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	task automatic write_reg(reg_idx_t idx, logic [15:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.write_setting(idx, value);
		@(posedge clk);
	endtask

	// Leaves in_valid high after acceptance so back-to-back requests need no gap.
	task automatic send_tick(bit level);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		beacon_level <= level;
		do @(posedge clk); while (in_stall);
		sb.note_tick(level);
	endtask

	task automatic send_ticks(int n, int low_pct);
		for (int i = 0; i < n; i++)
			send_tick($urandom_range(0, 99) >= low_pct);
	endtask

	// Sends n requests, bit 0 of the pattern first.
	task automatic send_bits(logic [31:0] bits, int n);
		for (int i = 0; i < n; i++)
			send_tick(bits[i]);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	initial begin
		int             sent;
		int             n;
		int             low_pct;
		int             close_mode;
		logic [15:0]    duty;
		logic [15:0]    lo_limit;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Start-up wait ignores the beacon; a huge delay holds it there.
		send_bits(32'b10, 2);
		wait_idle();
		write_reg(REG_START_DELAY, 16'hFFFF);
		send_bits(32'b0, 1);

		// Zero start delay, run, pause and dwell: every phase ends on its first tick.
		wait_idle();
		write_reg(REG_MOTOR_SPEED, 16'd255);
		write_reg(REG_RUN_TIME, 16'd0);
		write_reg(REG_PAUSE, 16'd0);
		write_reg(REG_IR_HOLD, 16'd0);
		write_reg(REG_DWELL, 16'd0);
		write_reg(REG_CYCLE_LIMIT, 16'd255);
		write_reg(REG_START_DELAY, 16'd0);
		send_bits(32'b0101, 4);

		// Detection with a zero dwell scores at once; motor duty of zero.
		wait_idle();
		write_reg(REG_RUN_TIME, 16'd3);
		write_reg(REG_PAUSE, 16'd1);
		write_reg(REG_MOTOR_SPEED, 16'd0);
		send_bits(32'b10111, 5);

		// With no hold window the beacon is lost on the first high sample.
		wait_idle();
		write_reg(REG_DWELL, 16'd4);
		send_bits(32'b1011, 4);

		// A very long hold window keeps the target through the whole dwell.
		wait_idle();
		write_reg(REG_IR_HOLD, 16'hFFFF);
		write_reg(REG_MOTOR_SPEED, 16'd255);
		send_bits(32'b11111011, 8);

		// Running the counter up to its top value costs four ticks per cycle,
		// so that ending keeps room for those ticks in the request budget.
		close_mode = $urandom_range(0, 2);
		sent = 0;
		while (sent < 950 && (close_mode != 2 ||
				sent + 4 * (255 - int'(sb.cycle_count)) < 950)) begin
			wait_idle();
			calm = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 3))
				0:       duty = 16'd0;
				1:       duty = 16'd255;
				default: duty = 16'($urandom_range(0, 255));
			endcase
			lo_limit = (sb.cycle_count < 200) ? 16'd200 : 16'd255;
			write_reg(REG_MOTOR_SPEED, duty);
			write_reg(REG_RUN_TIME, pick_span(12));
			write_reg(REG_PAUSE, pick_span(6));
			write_reg(REG_IR_HOLD, pick_span(6));
			write_reg(REG_DWELL, pick_span(10));
			write_reg(REG_CYCLE_LIMIT, 16'($urandom_range(lo_limit, 255)));
			write_reg(REG_START_DELAY, 16'($urandom_range(0, 65535)));
			case ($urandom_range(0, 3))
				0:       low_pct = 3;
				1:       low_pct = 25;
				2:       low_pct = 60;
				default: low_pct = 95;
			endcase
			n = $urandom_range(15, 50);
			send_ticks(n, low_pct);
			sent += n;
		end

		// Close the sequence by a zero limit, by the current cycle, or by
		// letting the cycle counter run up to its top value.
		wait_idle();
		calm = ($urandom_range(0, 1) == 0);
		write_reg(REG_RUN_TIME, 16'd0);
		write_reg(REG_PAUSE, 16'd0);
		write_reg(REG_DWELL, 16'($urandom_range(0, 3)));
		case (close_mode)
			0:       write_reg(REG_CYCLE_LIMIT, 16'd0);
			1:       write_reg(REG_CYCLE_LIMIT, 16'(sb.cycle_count));
			default: write_reg(REG_CYCLE_LIMIT, 16'd255);
		endcase
		while (sb.phase != PH_DONE)
			send_ticks(1, 50);
		send_ticks(8, 50);

		wait_idle();
		repeat (4) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
